@@ hdl/assert_macros.svh @@
// Assertion macros for the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/hwfir_pkg.sv @@
// Package: constants, types and coefficient functions of the Hann window FIR filter.
package hwfir_pkg;

	localparam int MAX_TAPS       = 40;
	localparam int COEF_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS  = 16;
	localparam int SMP_W          = 8;
	localparam int LEN_W          = 16;
	localparam int OUT_W          = 24;
	localparam int OFS_W          = 5;
	localparam int COEF_W         = COEF_FRAC_BITS - 3;
	localparam int PROD_W         = SMP_W + COEF_W;
	localparam int SUM_W          = COEF_FRAC_BITS + SMP_W + 1;
	localparam int RES_W          = SUM_W - COEF_FRAC_BITS + OUT_FRAC_BITS;
	localparam int GROUP          = 8;
	localparam int NUM_GRP        = (MAX_TAPS + GROUP - 1) / GROUP;
	localparam int TAB_LEN        = 40;

	localparam logic [LEN_W-1:0] LEN_MIN = 16'd400;
	localparam logic [LEN_W-1:0] LEN_30  = 16'd500;
	localparam logic [LEN_W-1:0] LEN_40  = 16'd700;

	localparam logic [1:0] WIN_20 = 2'd0;
	localparam logic [1:0] WIN_30 = 2'd1;
	localparam logic [1:0] WIN_40 = 2'd2;

	localparam int unsigned WIN20_MU [TAB_LEN] = '{
		0, 2850, 11100, 23840, 39710, 56980, 73770, 88280, 98920, 104550,
		104550, 98920, 88280, 73770, 56980, 39710, 23840, 11100, 2850, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	localparam int unsigned WIN30_MU [TAB_LEN] = '{
		0, 806, 3187, 7031, 12159, 18331, 25258, 32616, 40061, 47246,
		53834, 59517, 64030, 67160, 68763, 68763, 67160, 64030, 59517, 53834,
		47246, 40061, 32616, 25258, 18331, 12159, 7031, 3187, 806, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	localparam int unsigned WIN40_MU [TAB_LEN] = '{
		0, 332, 1320, 2937, 5142, 7879, 11075, 14649, 18507, 22550,
		26673, 30770, 34733, 38462, 41858, 44834, 47313, 49230, 50537, 51199,
		51199, 50537, 49230, 47313, 44834, 41858, 38462, 34733, 30770, 26673,
		22550, 18507, 14649, 11075, 7879, 5142, 2937, 1320, 332, 0};

	typedef logic [MAX_TAPS-1:0][SMP_W-1:0] hist_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] sel;
		logic       last;
	} ctrl_t;

	function automatic longint unsigned win_mu(logic [1:0] sel, int idx);
		longint unsigned mu;
		mu = 0;
		if (idx < TAB_LEN) begin
			case (sel)
				WIN_20:  mu = longint'(WIN20_MU[idx]);
				WIN_30:  mu = longint'(WIN30_MU[idx]);
				default: mu = longint'(WIN40_MU[idx]);
			endcase
		end
		return mu;
	endfunction

	// Millionths to Q0.COEF_FRAC_BITS, round to nearest.
	function automatic logic [COEF_W-1:0] win_coef(logic [1:0] sel, int idx);
		longint unsigned scaled;
		scaled = (win_mu(sel, idx) << COEF_FRAC_BITS) + 64'd500000;
		return COEF_W'(scaled / 64'd1000000);
	endfunction

	function automatic logic [OFS_W-1:0] group_offset(logic [1:0] sel);
		logic [OFS_W-1:0] ofs;
		case (sel)
			WIN_20:  ofs = 5'd9;
			WIN_30:  ofs = 5'd14;
			default: ofs = 5'd19;
		endcase
		return ofs;
	endfunction

endpackage

@@ hdl/hwfir_front.sv @@
// Input stage: length register, block sample count, delay line and window select.
module hwfir_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hwfir_pkg::SMP_W-1:0]   s_tdata,
	input  logic                          s_tuser,
	input  logic                          cfg_we,
	input  logic [hwfir_pkg::LEN_W-1:0]   cfg_wdata,
	input  logic                          s2_free,
	output hwfir_pkg::hist_t              hist,
	output hwfir_pkg::ctrl_t              ctrl
);
	import hwfir_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] count_q;
	hist_t            hist_q;
	logic             valid_s1;
	logic [1:0]       sel_s1;
	logic             last_s1;

	logic             accept;
	logic             len_ok;
	logic [LEN_W-1:0] base_cnt;
	logic [LEN_W-1:0] next_cnt;
	hist_t            hist_base;
	logic [1:0]       sel;

	assign s_tready = !valid_s1 || s2_free;
	assign accept   = s_tvalid && s_tready;
	assign len_ok   = len_q >= LEN_MIN;

	always_comb begin
		base_cnt  = s_tuser ? '0 : count_q;
		hist_base = s_tuser ? '0 : hist_q;
		next_cnt  = (base_cnt == {LEN_W{1'b1}}) ? base_cnt : base_cnt + 1'b1;
		if (len_q < LEN_30) begin
			sel = WIN_20;
		end else if (len_q < LEN_40) begin
			sel = WIN_30;
		end else begin
			sel = WIN_40;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			count_q  <= '0;
			hist_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1 <= len_ok;
				if (len_ok) begin
					hist_q  <= {hist_base[MAX_TAPS-2:0], s_tdata};
					count_q <= next_cnt;
				end else begin
					hist_q  <= hist_base;
					count_q <= base_cnt;
				end
			end else if (s2_free) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_s1  <= sel;
			last_s1 <= next_cnt == len_q;
		end
	end

	assign hist = hist_q;
	assign ctrl = '{valid: valid_s1, sel: sel_s1, last: last_s1};

endmodule

@@ hdl/hwfir_mac.sv @@
// Multiply-accumulate: tap products and group sums, final sum, rounding, saturation.
module hwfir_mac (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hwfir_pkg::hist_t     hist,
	input  hwfir_pkg::ctrl_t     ctrl,
	output logic                 s2_free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,
	output logic                 m_tlast
);
	import hwfir_pkg::*;

	logic [PROD_W-1:0] prod [MAX_TAPS];
	logic [SUM_W-1:0]  gsum [NUM_GRP];
	logic [SUM_W-1:0]  gsum_s2 [NUM_GRP];
	logic              valid_s2;
	logic [1:0]        sel_s2;
	logic              last_s2;
	logic              out_free;
	logic [SUM_W-1:0]  total;
	logic [RES_W-1:0]  res;
	logic [OUT_W-1:0]  filt;
	logic [OUT_W-1:0]  filt_q;
	logic [OFS_W-1:0]  ofs_q;
	logic              valid_q;
	logic              last_q;

	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_tap
		localparam logic [COEF_W-1:0] C20 = win_coef(WIN_20, i);
		localparam logic [COEF_W-1:0] C30 = win_coef(WIN_30, i);
		localparam logic [COEF_W-1:0] C40 = win_coef(WIN_40, i);
		logic [COEF_W-1:0] coef;
		always_comb begin
			case (ctrl.sel)
				WIN_20:  coef = C20;
				WIN_30:  coef = C30;
				default: coef = C40;
			endcase
			prod[i] = PROD_W'(hist[i]) * PROD_W'(coef);
		end
	end

	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			gsum[g] = '0;
			for (int j = 0; j < GROUP; j++) begin
				if (g * GROUP + j < MAX_TAPS) begin
					gsum[g] = gsum[g] + SUM_W'(prod[g * GROUP + j]);
				end
			end
		end
	end

	assign out_free = !valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= ctrl.valid;
			end
			if (out_free) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && ctrl.valid) begin
			gsum_s2 <= gsum;
			sel_s2  <= ctrl.sel;
			last_s2 <= ctrl.last;
		end
		if (out_free && valid_s2) begin
			filt_q <= filt;
			ofs_q  <= group_offset(sel_s2);
			last_q <= last_s2;
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			total = total + gsum_s2[g];
		end
	end

	if (COEF_FRAC_BITS > OUT_FRAC_BITS) begin : g_down
		localparam int SH = COEF_FRAC_BITS - OUT_FRAC_BITS;
		localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (SH - 1);
		logic [SUM_W-1:0] rounded;
		assign rounded = total + RND;
		assign res     = RES_W'(rounded >> SH);
	end else begin : g_up
		localparam int SH = OUT_FRAC_BITS - COEF_FRAC_BITS;
		assign res = RES_W'(total) << SH;
	end

	assign filt = (|res[RES_W-1:OUT_W]) ? {OUT_W{1'b1}} : res[OUT_W-1:0];

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(32 - OUT_W - OFS_W){1'b0}}, ofs_q, filt_q};
	assign m_tlast  = last_q;

endmodule

@@ hdl/hann_window_fir_filter.sv @@
// An accepted input word passes the input, group-sum and output registers on its way to its result word.
// Throughput: one word per cycle; s_tready drops only when the output holds under backpressure.
// Tap products are summed in groups and registered, the final sum is registered at the output.
// Inputs while the block length is below 400 give no output word.
// Reset clears the length register, sample count, delay line and all valid flags.
// Top level: Hann window FIR smoothing filter.
module hann_window_fir_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hwfir_pkg::SMP_W-1:0]   s_tdata,  // [7:0] sample
	input  logic                          s_tuser,  // [0] block_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,  // [23:0] filtered, [28:24] group_offset
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [hwfir_pkg::LEN_W-1:0]   cfg_wdata
);
	import hwfir_pkg::*;

	hist_t hist;
	ctrl_t ctrl;
	logic  s2_free;

	hwfir_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s2_free   (s2_free),
		.hist      (hist),
		.ctrl      (ctrl)
	);

	hwfir_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.hist     (hist),
		.ctrl     (ctrl),
		.s2_free  (s2_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ hdl/hwfir_chk.sv @@
// Port checker for the Hann window FIR filter, bound to the top level.
`include "assert_macros.svh"

module hwfir_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
	`CHK_SAME(a_ofs_legal, m_tvalid, m_tdata[28:24] == 5'd9 || m_tdata[28:24] == 5'd14 || m_tdata[28:24] == 5'd19, "group offset not 9, 14 or 19")
	`CHK_SAME(a_pad_zero, m_tvalid, m_tdata[31:29] == 3'd0, "tdata pad bits not zero")
	`CHK_SAME(a_ready_empty, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind hann_window_fir_filter hwfir_chk u_chk (.*);
